### src/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the coin change dispenser.
// Holds the coin value table, field widths, command codes and the
// command/status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ccs_pkg;

    // Number of coin kinds and the width of an index into them.
    localparam int NUM_KINDS = 8;
    localparam int IDX_W     = 3;

    // Fixed widths of the channel fields.
    localparam int CNT_W     = 8;
    localparam int AMT_IN_W  = 20;
    localparam int COIN_W    = 8;

    // Defaults for the top-level parameters.
    localparam int STOCK_BITS_DEF  = 8;
    localparam int AMOUNT_BITS_DEF = 20;

    // Index of the largest coin, where a change walk starts.
    localparam logic [IDX_W-1:0] IDX_TOP = 3'd7;
    localparam logic [IDX_W-1:0] IDX_BOT = 3'd0;

    // Request codes carried in the cmd field.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_CHANGE = 1'b1;

    // Coin values in cents, slot 0 is the smallest coin.
    typedef logic [COIN_W-1:0] t_coin;
    localparam t_coin COIN_VALUE [NUM_KINDS] = '{
        8'd1, 8'd2, 8'd5, 8'd10, 8'd20, 8'd50, 8'd100, 8'd200
    };

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             in_ready;
        logic             load_wr;
        logic             start;
        logic             mul_step;
        logic             upd_step;
        logic             publish;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_change;
        logic req_underpaid;
        logic out_free;
    } t_dp_status;

endpackage

### src/ccs_req_if.sv
// ----------------------------------------------------------------------------
// ccs_req_if: request channel of the coin change dispenser.
// One beat carries either a stock load or a change request.
// ----------------------------------------------------------------------------
interface ccs_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [ccs_pkg::IDX_W-1:0]     slot;
    logic [ccs_pkg::CNT_W-1:0]     stock_value;
    logic [ccs_pkg::AMT_IN_W-1:0]  price_cents;
    logic [ccs_pkg::AMT_IN_W-1:0]  paid_cents;

    modport source (
        output valid, cmd, slot, stock_value, price_cents, paid_cents,
        input  ready
    );

    modport sink (
        input  valid, cmd, slot, stock_value, price_cents, paid_cents,
        output ready
    );
endinterface

### src/ccs_res_if.sv
// ----------------------------------------------------------------------------
// ccs_res_if: result channel of the coin change dispenser.
// One beat carries the coin counts of one change request and two flags.
// ----------------------------------------------------------------------------
interface ccs_res_if;
    logic                       valid;
    logic                       ready;
    logic [ccs_pkg::CNT_W-1:0]  coins_200;
    logic [ccs_pkg::CNT_W-1:0]  coins_100;
    logic [ccs_pkg::CNT_W-1:0]  coins_50;
    logic [ccs_pkg::CNT_W-1:0]  coins_20;
    logic [ccs_pkg::CNT_W-1:0]  coins_10;
    logic [ccs_pkg::CNT_W-1:0]  coins_5;
    logic [ccs_pkg::CNT_W-1:0]  coins_2;
    logic [ccs_pkg::CNT_W-1:0]  coins_1;
    logic                       change_complete;
    logic                       underpaid;

    modport source (
        output valid, coins_200, coins_100, coins_50, coins_20, coins_10,
               coins_5, coins_2, coins_1, change_complete, underpaid,
        input  ready
    );

    modport sink (
        input  valid, coins_200, coins_100, coins_50, coins_20, coins_10,
               coins_5, coins_2, coins_1, change_complete, underpaid,
        output ready
    );
endinterface

### src/ccs_ctrl.sv
// ----------------------------------------------------------------------------
// ccs_ctrl: controller of the coin change dispenser.
// Accepts request beats, walks the coin kinds from largest to smallest in
// two steps each, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module ccs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  ccs_pkg::t_dp_status  i_status,
    output ccs_pkg::t_dp_cmd     o_cmd
);

    ccs_pkg::t_state                r_state;
    ccs_pkg::t_state                n_state;
    logic [ccs_pkg::IDX_W-1:0]      r_idx;
    logic [ccs_pkg::IDX_W-1:0]      n_idx;

    // State and coin index registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccs_pkg::S_IDLE;
            r_idx   <= ccs_pkg::IDX_TOP;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        o_cmd          = '0;
        o_cmd.idx      = r_idx;
        unique case (r_state)
            ccs_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_status.req_change) begin
                        o_cmd.start = 1'b1;
                        n_idx       = ccs_pkg::IDX_TOP;
                        n_state     = i_status.req_underpaid ? ccs_pkg::S_DONE
                                                             : ccs_pkg::S_MUL;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            ccs_pkg::S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state        = ccs_pkg::S_UPD;
            end
            ccs_pkg::S_UPD: begin
                o_cmd.upd_step = 1'b1;
                if (r_idx == ccs_pkg::IDX_BOT) begin
                    n_state = ccs_pkg::S_DONE;
                end else begin
                    n_idx   = r_idx - 3'd1;
                    n_state = ccs_pkg::S_MUL;
                end
            end
            ccs_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ccs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ccs_pkg::S_IDLE;
            end
        endcase
    end

    // A change request that is paid in full starts at the largest coin.
    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ccs_pkg::S_IDLE && i_req_valid && i_status.req_change &&
         !i_status.req_underpaid)
        |=> (r_state == ccs_pkg::S_MUL && r_idx == ccs_pkg::IDX_TOP))
        else $error("change walk did not start at the largest coin");

    // The walk moves down one coin kind per update step.
    a_walk_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ccs_pkg::S_UPD && r_idx != ccs_pkg::IDX_BOT)
        |=> (r_state == ccs_pkg::S_MUL && r_idx == $past(r_idx) - 3'd1))
        else $error("coin walk skipped or repeated a kind");

endmodule

### src/ccs_datapath.sv
// ----------------------------------------------------------------------------
// ccs_datapath: stock registers, remaining change and result registers.
// Each coin kind is handled in two steps: a reciprocal multiply with a
// stock bound compare, then a one-step quotient correction and update.
// ----------------------------------------------------------------------------
module ccs_datapath #(
    parameter int STOCK_BITS  = ccs_pkg::STOCK_BITS_DEF,
    parameter int AMOUNT_BITS = ccs_pkg::AMOUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ccs_pkg::t_dp_cmd     i_cmd,
    output ccs_pkg::t_dp_status  o_status,
    ccs_req_if.sink              i_req,
    ccs_res_if.source            o_res
);

    localparam int SW  = STOCK_BITS;
    localparam int AW  = AMOUNT_BITS;
    localparam int CW  = ccs_pkg::CNT_W;
    localparam int VW  = ccs_pkg::COIN_W;
    // Width of a full stock's worth of one coin kind in cents.
    localparam int QW  = SW + VW;
    localparam int PW  = 2 * QW + 1;
    localparam int XW  = (AW > QW) ? AW : QW;
    localparam int SEW = (SW > CW) ? SW : CW;
    localparam int AEW = (AW > ccs_pkg::AMT_IN_W) ? AW : ccs_pkg::AMT_IN_W;
    localparam int NK  = ccs_pkg::NUM_KINDS;

    // Stock and walk registers.
    logic [SW-1:0]  r_stock [NK];
    logic [CW-1:0]  r_work  [NK];
    logic [AW-1:0]  r_rem;
    logic           r_underpaid;
    logic [PW-1:0]  r_prod;
    logic [QW-1:0]  r_full;
    logic           r_take_all;

    // Output register.
    logic           r_out_valid;
    logic [CW-1:0]  r_out_coins [NK];
    logic           r_out_complete;
    logic           r_out_underpaid;

    // Reciprocals floor(2^QW / value) for each coin kind.
    logic [QW:0]    recip_tab [NK];

    for (genvar k = 0; k < NK; k++) begin : g_recip
        localparam longint unsigned RECIP =
            (64'd1 << QW) / 64'(ccs_pkg::COIN_VALUE[k]);
        assign recip_tab[k] = RECIP[QW:0];
    end

    // Request fields taken to the configured widths.
    logic [SEW-1:0] stock_ext;
    logic [SW-1:0]  stock_in;
    logic [AEW-1:0] price_ext;
    logic [AEW-1:0] paid_ext;
    logic [AW-1:0]  price_w;
    logic [AW-1:0]  paid_w;
    logic           underpaid_in;

    assign stock_ext    = SEW'(i_req.stock_value);
    assign stock_in     = stock_ext[SW-1:0];
    assign price_ext    = AEW'(i_req.price_cents);
    assign paid_ext     = AEW'(i_req.paid_cents);
    assign price_w      = price_ext[AW-1:0];
    assign paid_w       = paid_ext[AW-1:0];
    assign underpaid_in = (paid_w < price_w);

    // Current coin kind.
    logic [VW-1:0]  cur_val;
    logic [SW-1:0]  cur_stock;
    logic [XW-1:0]  rem_x;
    logic [QW-1:0]  x_low;
    logic [QW-1:0]  full_now;

    assign cur_val   = ccs_pkg::COIN_VALUE[i_cmd.idx];
    assign cur_stock = r_stock[i_cmd.idx];
    assign rem_x     = XW'(r_rem);
    assign x_low     = rem_x[QW-1:0];
    assign full_now  = QW'(cur_stock) * QW'(cur_val);

    // Quotient correction and update of the remaining change.
    logic [QW-1:0]  q0;
    logic [QW-1:0]  q0_val;
    logic [QW-1:0]  r0;
    logic           fix;
    logic [QW-1:0]  q1;
    logic [QW-1:0]  r1;
    logic [SW-1:0]  used;
    logic [SEW-1:0] used_ext;
    logic [XW-1:0]  rem_less_full;
    logic [AW-1:0]  rem_next;

    assign q0            = r_prod[2*QW-1:QW];
    assign q0_val        = q0 * QW'(cur_val);
    assign r0            = x_low - q0_val;
    assign fix           = (r0 >= QW'(cur_val));
    assign q1            = fix ? (q0 + QW'(1)) : q0;
    assign r1            = fix ? (r0 - QW'(cur_val)) : r0;
    assign used          = r_take_all ? cur_stock : q1[SW-1:0];
    assign used_ext      = SEW'(used);
    assign rem_less_full = rem_x - XW'(r_full);
    assign rem_next      = r_take_all ? rem_less_full[AW-1:0] : AW'(r1);

    // Status toward the controller.
    assign o_status.req_change    = (i_req.cmd == ccs_pkg::CMD_CHANGE);
    assign o_status.req_underpaid = underpaid_in;
    assign o_status.out_free      = !r_out_valid || o_res.ready;

    assign i_req.ready = i_cmd.in_ready;

    // Coin stock, cleared at reset, written by loads and by the walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NK; k++) begin
                r_stock[k] <= '0;
            end
        end else if (i_cmd.load_wr) begin
            r_stock[i_req.slot] <= stock_in;
        end else if (i_cmd.upd_step) begin
            r_stock[i_cmd.idx] <= cur_stock - used;
        end
    end

    // Walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem       <= paid_w - price_w;
            r_underpaid <= underpaid_in;
            for (int k = 0; k < NK; k++) begin
                r_work[k] <= '0;
            end
        end
        if (i_cmd.mul_step) begin
            r_prod     <= PW'(x_low) * PW'(recip_tab[i_cmd.idx]);
            r_full     <= full_now;
            r_take_all <= (rem_x >= XW'(full_now));
        end
        if (i_cmd.upd_step) begin
            r_rem              <= rem_next;
            r_work[i_cmd.idx]  <= used_ext[CW-1:0];
        end
    end

    // Output beat valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output beat payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_coins     <= r_work;
            r_out_complete  <= !r_underpaid && (r_rem == '0);
            r_out_underpaid <= r_underpaid;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.coins_200       = r_out_coins[7];
    assign o_res.coins_100       = r_out_coins[6];
    assign o_res.coins_50        = r_out_coins[5];
    assign o_res.coins_20        = r_out_coins[4];
    assign o_res.coins_10        = r_out_coins[3];
    assign o_res.coins_5         = r_out_coins[2];
    assign o_res.coins_2         = r_out_coins[1];
    assign o_res.coins_1         = r_out_coins[0];
    assign o_res.change_complete = r_out_complete;
    assign o_res.underpaid       = r_out_underpaid;

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> (!r_out_valid || o_res.ready))
        else $error("result published over an untaken beat");

    // The remaining change never grows during the walk.
    a_rem_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_step |=> (r_rem <= $past(r_rem)))
        else $error("remaining change increased");

    // Paying out never adds coins to the stock.
    a_stock_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_step |=> (r_stock[$past(i_cmd.idx)] <= $past(cur_stock)))
        else $error("coin stock increased during payout");

endmodule

### src/coin_change_with_stock_core.sv
// ----------------------------------------------------------------------------
// coin_change_with_stock_core: change dispenser with a limited coin stock.
// A load beat is written to the stock and the next beat can follow at once.
// A change request walks the eight coin kinds, a multiply step and an update
// step for each, then publishes its result to the output register once that is
// free; an underpaid request skips the walk. Then the next request is taken.
// Synchronous active-low reset empties the stock and drops the output beat.
// ----------------------------------------------------------------------------
module coin_change_with_stock_core #(
    parameter int STOCK_BITS  = ccs_pkg::STOCK_BITS_DEF,
    parameter int AMOUNT_BITS = ccs_pkg::AMOUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccs_req_if.sink     i_req,
    ccs_res_if.source   o_res
);

    ccs_pkg::t_dp_cmd     dp_cmd;
    ccs_pkg::t_dp_status  dp_status;

    // Sequencer for loads and change walks.
    ccs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Stock, arithmetic and output register.
    ccs_datapath #(
        .STOCK_BITS  (STOCK_BITS),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .i_req    (i_req),
        .o_res    (o_res)
    );

endmodule
